// ===== rtl/pack_record_scanner_core_macros.svh =====
// Assertion helpers for the scanner RTL.
`ifndef PACK_RECORD_SCANNER_CORE_MACROS_SVH
`define PACK_RECORD_SCANNER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PRS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/prs_pkg.sv =====
package prs_pkg;

    // Address counter width; anything from 16 to 24 bits works.
    localparam int AddrBits    = 16;
    localparam int EndAddrBits = 16;
    localparam int ByteBits    = 8;
    localparam int LenBits     = 16;
    localparam int NameBits    = 64;
    localparam int KindBits    = 3;
    localparam int CfgIdxBits  = 8;
    localparam int CfgDataBits = 16;

    localparam logic [ByteBits-1:0] StartOffset     = 8'h0A;
    localparam logic [ByteBits-1:0] TypeLong        = 8'h80;
    localparam logic [ByteBits-1:0] TypeEnd         = 8'hFF;
    localparam logic [ByteBits-1:0] FileEntryLen    = 8'h09;
    localparam logic [ByteBits-1:0] TypeFileEntry   = 8'h81;
    localparam logic [ByteBits-1:0] ResetRecordType = 8'h90;
    localparam logic [ByteBits-1:0] MapTypeLow      = 8'h91;
    localparam logic [ByteBits-1:0] MapTypeHigh     = 8'hFE;

    // Used-type map covers types 0x91..0xFE, searched in groups.
    localparam int MapDepth      = 110;
    localparam int MapIdxBits    = $clog2(MapDepth);
    localparam int MapGroupSize  = 10;
    localparam int MapGroups     = MapDepth / MapGroupSize;
    localparam int GroupPosBits  = $clog2(MapGroupSize);

    localparam logic [KindBits-1:0] EvShort   = 3'd0;
    localparam logic [KindBits-1:0] EvFile    = 3'd1;
    localparam logic [KindBits-1:0] EvLong    = 3'd2;
    localparam logic [KindBits-1:0] EvEnd     = 3'd3;
    localparam logic [KindBits-1:0] EvZeroLen = 3'd4;
    localparam logic [KindBits-1:0] EvBadEnd  = 3'd5;

    localparam logic [CfgIdxBits-1:0] RegCurrentType  = 8'd0;
    localparam logic [CfgIdxBits-1:0] RegWantedNumber = 8'd1;

    localparam logic [LenBits-1:0] ResetWantedNumber = 16'd1;

    typedef logic [MapDepth-1:0] prs_map_t;

    typedef struct packed {
        logic [ByteBits-1:0] current_record_type;
        logic [LenBits-1:0]  wanted_record_number;
    } prs_cfg_t;

    typedef struct packed {
        logic [KindBits-1:0]    kind;
        logic [LenBits-1:0]     record_length;
        logic [ByteBits-1:0]    rec_type;
        logic [EndAddrBits-1:0] end_address;
        logic [NameBits-1:0]    file_name;
        logic [ByteBits-1:0]    file_type;
        logic                   is_wanted;
        logic [LenBits-1:0]     match_count;
        logic [ByteBits-1:0]    free_type;
    } prs_result_t;

endpackage

// ===== rtl/prs_byte_if.sv =====
interface prs_byte_if;
    import prs_pkg::*;

    logic                valid;
    logic                ready;
    logic [ByteBits-1:0] pack_byte;
    logic                start_req;

    modport source (output valid, output pack_byte, output start_req, input ready);
    modport sink (input valid, input pack_byte, input start_req, output ready);
endinterface

// ===== rtl/prs_event_if.sv =====
interface prs_event_if;
    import prs_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [KindBits-1:0]    event_kind;
    logic [LenBits-1:0]     record_length;
    logic [ByteBits-1:0]    rec_type;
    logic [EndAddrBits-1:0] end_address;
    logic [NameBits-1:0]    file_name;
    logic [ByteBits-1:0]    file_type;
    logic                   is_wanted;
    logic [LenBits-1:0]     match_count;
    logic [ByteBits-1:0]    free_type;

    modport source (
        output valid, output event_kind, output record_length, output rec_type,
        output end_address, output file_name, output file_type, output is_wanted,
        output match_count, output free_type, input ready
    );
    modport sink (
        input valid, input event_kind, input record_length, input rec_type,
        input end_address, input file_name, input file_type, input is_wanted,
        input match_count, input free_type, output ready
    );
endinterface

// ===== rtl/prs_cfg_if.sv =====
interface prs_cfg_if;
    import prs_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CfgIdxBits-1:0]  index;
    logic [CfgDataBits-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/prs_free_search.sv =====
module prs_free_search (
    input  logic                          clk,
    input  logic                          rst_n,
    input  prs_pkg::prs_map_t             used_map,
    output logic [prs_pkg::ByteBits-1:0]  free_type
);
    import prs_pkg::*;

    logic [MapGroups-1:0]                   grp_found_reg;
    logic [MapGroups-1:0]                   grp_found_next;
    logic [MapGroups-1:0][GroupPosBits-1:0] grp_pos_reg;
    logic [MapGroups-1:0][GroupPosBits-1:0] grp_pos_next;

    // First level: highest clear bit inside each group, registered every cycle.
    // The map input is the value the map takes at the coming edge, so the group
    // registers always describe the map as it is stored.
    always_comb
    begin
        for (int g = 0; g < MapGroups; g++)
        begin
            grp_found_next[g] = 1'b0;
            grp_pos_next[g]   = '0;
            for (int j = 0; j < MapGroupSize; j++)
            begin
                if (!used_map[g * MapGroupSize + j])
                begin
                    grp_found_next[g] = 1'b1;
                    grp_pos_next[g]   = GroupPosBits'(j);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_found_reg <= '1;
            for (int g = 0; g < MapGroups; g++)
            begin
                grp_pos_reg[g] <= GroupPosBits'(MapGroupSize - 1);
            end
        end
        else
        begin
            grp_found_reg <= grp_found_next;
            grp_pos_reg   <= grp_pos_next;
        end
    end

    // Second level: the highest group that still has a free type wins.
    always_comb
    begin
        free_type = '0;
        for (int g = 0; g < MapGroups; g++)
        begin
            if (grp_found_reg[g])
            begin
                free_type = MapTypeLow + ByteBits'(g * MapGroupSize)
                          + ByteBits'(grp_pos_reg[g]);
            end
        end
    end

endmodule

// ===== rtl/prs_scan.sv =====
`include "pack_record_scanner_core_macros.svh"

module prs_scan (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [prs_pkg::ByteBits-1:0]  pack_byte,
    input  logic                          start_req,
    input  prs_pkg::prs_cfg_t             cfg,
    input  logic [prs_pkg::ByteBits-1:0]  free_type,
    output prs_pkg::prs_map_t             used_map,
    output logic                          res_valid,
    output prs_pkg::prs_result_t          res
);
    import prs_pkg::*;

    localparam logic [2:0] PhIdle = 3'd0;
    localparam logic [2:0] PhLen  = 3'd1;
    localparam logic [2:0] PhType = 3'd2;
    localparam logic [2:0] PhLhi  = 3'd3;
    localparam logic [2:0] PhLlo  = 3'd4;
    localparam logic [2:0] PhBody = 3'd5;
    localparam logic [2:0] PhSkip = 3'd6;
    localparam logic [2:0] PhDone = 3'd7;

    logic [2:0]          phase_reg,  phase_next;
    logic [ByteBits-1:0] length_reg, length_next;
    logic [ByteBits-1:0] type_reg,   type_next;
    logic [LenBits-1:0]  rem_reg,    rem_next;
    logic [LenBits-1:0]  block_reg,  block_next;
    logic [AddrBits-1:0] addr_reg,   addr_next;
    logic [NameBits-1:0] name_reg,   name_next;
    logic [LenBits-1:0]  match_reg,  match_next;
    prs_map_t            map_reg,    map_next;

    logic [2:0]            ph;
    logic [AddrBits-1:0]   addr_cur;
    logic [AddrBits-1:0]   addr_inc;
    logic [AddrBits-1:0]   addr_dec;
    logic [LenBits-1:0]    match_cur;
    logic [LenBits-1:0]    match_inc;
    logic                  hit;
    logic [LenBits-1:0]    block_full;
    logic [MapIdxBits-1:0] map_idx;

    assign used_map = map_next;

    // A start beat behaves as if the scan had just been restarted at offset 0x0a.
    assign ph         = start_req ? PhLen : phase_reg;
    assign addr_cur   = start_req ? AddrBits'(StartOffset) : addr_reg;
    assign match_cur  = start_req ? '0 : match_reg;
    assign addr_inc   = addr_cur + AddrBits'(1);
    assign addr_dec   = addr_cur - AddrBits'(1);
    assign match_inc  = match_cur + LenBits'(1);
    assign hit        = (type_reg == cfg.current_record_type) && (match_cur != '1);
    assign block_full = {block_reg[LenBits-1:ByteBits], pack_byte};
    assign map_idx    = MapIdxBits'(pack_byte - MapTypeLow);

    always_comb
    begin
        phase_next  = phase_reg;
        length_next = length_reg;
        type_next   = type_reg;
        rem_next    = rem_reg;
        block_next  = block_reg;
        addr_next   = addr_reg;
        name_next   = name_reg;
        match_next  = match_reg;
        map_next    = map_reg;
        res_valid   = 1'b0;
        res         = '0;
        res.rec_type      = type_reg;
        res.record_length = LenBits'(length_reg);
        res.end_address   = addr_inc[EndAddrBits-1:0];

        if (step)
        begin
            phase_next = ph;
            addr_next  = addr_cur;
            match_next = match_cur;
            if (start_req)
            begin
                map_next = '0;
            end
            if (ph != PhIdle && ph != PhDone)
            begin
                addr_next = addr_inc;
            end

            case (ph)
                PhLen:
                begin
                    length_next = pack_byte;
                    phase_next  = PhType;
                end
                PhType:
                begin
                    type_next    = pack_byte;
                    res.rec_type = pack_byte;
                    if (length_reg == '0)
                    begin
                        res_valid  = 1'b1;
                        res.kind   = EvZeroLen;
                        phase_next = PhDone;
                    end
                    else if (pack_byte == TypeLong)
                    begin
                        phase_next = PhLhi;
                    end
                    else if (pack_byte != TypeEnd)
                    begin
                        rem_next   = LenBits'(length_reg);
                        name_next  = '0;
                        phase_next = PhBody;
                    end
                    else if (length_reg == TypeEnd)
                    begin
                        res_valid       = 1'b1;
                        res.kind        = EvEnd;
                        res.end_address = addr_dec[EndAddrBits-1:0];
                        res.free_type   = free_type;
                        phase_next      = PhDone;
                    end
                    else
                    begin
                        res_valid  = 1'b1;
                        res.kind   = EvBadEnd;
                        phase_next = PhDone;
                    end
                end
                PhLhi:
                begin
                    block_next = {pack_byte, ByteBits'(0)};
                    phase_next = PhLlo;
                end
                PhLlo:
                begin
                    block_next = block_full;
                    rem_next   = block_full;
                    if (block_full == '0)
                    begin
                        res_valid         = 1'b1;
                        res.kind          = EvLong;
                        res.record_length = block_full;
                        phase_next        = PhLen;
                    end
                    else
                    begin
                        phase_next = PhSkip;
                    end
                end
                PhSkip:
                begin
                    rem_next = rem_reg - LenBits'(1);
                    if (rem_reg == LenBits'(1))
                    begin
                        res_valid         = 1'b1;
                        res.kind          = EvLong;
                        res.record_length = block_reg;
                        phase_next        = PhLen;
                    end
                end
                PhBody:
                begin
                    if (rem_reg > LenBits'(1))
                    begin
                        name_next = {name_reg[NameBits-ByteBits-1:0], pack_byte};
                        rem_next  = rem_reg - LenBits'(1);
                    end
                    else
                    begin
                        rem_next   = '0;
                        phase_next = PhLen;
                        res_valid  = 1'b1;
                        if (hit)
                        begin
                            match_next    = match_inc;
                            res.is_wanted = (cfg.wanted_record_number != '0)
                                         && (match_inc == cfg.wanted_record_number);
                        end
                        if (length_reg == FileEntryLen && type_reg == TypeFileEntry)
                        begin
                            // Only types the free search covers are worth marking.
                            if (pack_byte >= MapTypeLow && pack_byte <= MapTypeHigh)
                            begin
                                map_next[map_idx] = 1'b1;
                            end
                            res.kind      = EvFile;
                            res.file_name = name_reg;
                            res.file_type = pack_byte;
                        end
                        else
                        begin
                            res.kind = EvShort;
                        end
                    end
                end
                default:
                begin
                    phase_next = ph;
                end
            endcase
        end
        res.match_count = match_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PhIdle;
            length_reg <= '0;
            type_reg   <= '0;
            rem_reg    <= '0;
            block_reg  <= '0;
            addr_reg   <= AddrBits'(StartOffset);
            name_reg   <= '0;
            match_reg  <= '0;
            map_reg    <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            length_reg <= length_next;
            type_reg   <= type_next;
            rem_reg    <= rem_next;
            block_reg  <= block_next;
            addr_reg   <= addr_next;
            name_reg   <= name_next;
            match_reg  <= match_next;
            map_reg    <= map_next;
        end
    end

    `PRS_ASSERT_IMPL(a_free_only_at_end, clk, rst_n,
        res_valid && res.kind != EvEnd, res.free_type == '0,
        "free type reported outside an end event")
    `PRS_ASSERT_IMPL(a_name_only_in_file, clk, rst_n,
        res_valid && res.kind != EvFile, res.file_name == '0 && res.file_type == '0,
        "file fields set outside a file entry")
    `PRS_ASSERT_NEXT(a_done_holds, clk, rst_n,
        phase_reg == PhDone && !(step && start_req), phase_reg == PhDone,
        "scan left the finished state without a start beat")
    `PRS_ASSERT_NEXT(a_count_monotonic, clk, rst_n,
        !(step && start_req), match_reg >= $past(match_reg),
        "match count went down without a start beat")
    `PRS_ASSERT_IMPL(a_wanted_is_count, clk, rst_n,
        res_valid && res.is_wanted,
        res.match_count == cfg.wanted_record_number && res.match_count != '0,
        "wanted flag does not agree with the match count")

endmodule

// ===== rtl/pack_record_scanner_core.sv =====
// An accepted input beat is held in the input register, then the scan logic writes its
// result into the result register that drives event_out.
// Throughput: one pack byte per cycle unless event_out stalls; the result register frees
// the input side whenever it is empty or being taken in the same cycle.
// Reset (rst_n, asynchronous): scan idle until a start beat, address 0x0a, used-type
// map and match count clear, current_record_type 0x90, wanted_record_number 1.
module pack_record_scanner_core (
    input  logic        clk,
    input  logic        rst_n,
    prs_byte_if.sink    byte_in,
    prs_event_if.source event_out,
    prs_cfg_if.sink     cfg_in
);
    import prs_pkg::*;

    prs_cfg_t            cfg_reg;
    logic                s1_valid_reg;
    logic [ByteBits-1:0] s1_byte_reg;
    logic                s1_start_reg;
    logic                out_valid_reg;
    prs_result_t         out_data_reg;

    logic                advance;
    logic                step;
    logic                res_valid;
    prs_result_t         res;
    prs_map_t            used_map;
    logic [ByteBits-1:0] free_type;

    assign advance       = !out_valid_reg || event_out.ready;
    assign step          = s1_valid_reg && advance;
    assign byte_in.ready = !s1_valid_reg || advance;
    assign cfg_in.ready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.current_record_type  <= ResetRecordType;
            cfg_reg.wanted_record_number <= ResetWantedNumber;
        end
        else if (cfg_in.valid)
        begin
            case (cfg_in.index)
                RegCurrentType:  cfg_reg.current_record_type  <= cfg_in.data[ByteBits-1:0];
                RegWantedNumber: cfg_reg.wanted_record_number <= cfg_in.data[LenBits-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (byte_in.ready)
            begin
                s1_valid_reg <= byte_in.valid;
            end
            if (advance)
            begin
                out_valid_reg <= step && res_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_in.valid && byte_in.ready)
        begin
            s1_byte_reg  <= byte_in.pack_byte;
            s1_start_reg <= byte_in.start_req;
        end
        if (step && res_valid)
        begin
            out_data_reg <= res;
        end
    end

    prs_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .pack_byte (s1_byte_reg),
        .start_req (s1_start_reg),
        .cfg       (cfg_reg),
        .free_type (free_type),
        .used_map  (used_map),
        .res_valid (res_valid),
        .res       (res)
    );

    prs_free_search u_free_search (
        .clk       (clk),
        .rst_n     (rst_n),
        .used_map  (used_map),
        .free_type (free_type)
    );

    assign event_out.valid         = out_valid_reg;
    assign event_out.event_kind    = out_data_reg.kind;
    assign event_out.record_length = out_data_reg.record_length;
    assign event_out.rec_type      = out_data_reg.rec_type;
    assign event_out.end_address   = out_data_reg.end_address;
    assign event_out.file_name     = out_data_reg.file_name;
    assign event_out.file_type     = out_data_reg.file_type;
    assign event_out.is_wanted     = out_data_reg.is_wanted;
    assign event_out.match_count   = out_data_reg.match_count;
    assign event_out.free_type     = out_data_reg.free_type;

endmodule
